### rtl/camp_pkg.sv
// Shared widths, status codes and types for the camera position solver.
// Used by camp_div and camera_position_from_two_rays; depends on nothing.
`default_nettype none

package camp_pkg;

    localparam int IN_W     = 32;   // input fields
    localparam int POS_W    = 48;   // Q32.16 results
    localparam int THR_W    = 41;   // threshold register
    localparam int DD_W     = 66;   // squared feature separation
    localparam int SUM_W    = 33;   // feature differences and sums
    localparam int B_W      = 64;   // right-hand side terms, units of 2^-40
    localparam int R_W      = 65;   // r1, r2
    localparam int T_W      = 96;   // one feature times one rhs term
    localparam int M_W      = 99;   // su*r1 + sv*r2
    localparam int N_W      = 100;  // numerator of cz
    localparam int D_W      = 67;   // doubled divisor
    localparam int REM_W    = 116;  // divider remainder, wide enough for D << POS_W
    localparam int PR_W     = 83;   // r + s*cz
    localparam int QMAG_W   = 64;   // magnitude going into the clamp
    localparam int RHS_SHIFT = 24;  // Q16.16 times 2^24 gives units of 2^-40
    localparam int CZ_SPLIT  = 24;  // cz is multiplied in two halves
    localparam int OUT_SHIFT = 25;  // halving and 2^-40 to 2^-16

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_RANK = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic [QMAG_W-1:0] POS_MAX_MAG =
        (QMAG_W'(1) << (POS_W - 1)) - QMAG_W'(1);

    typedef struct packed {
        logic [R_W-1:0]   r1;
        logic [R_W-1:0]   r2;
        logic [SUM_W-1:0] su;
        logic [SUM_W-1:0] sv;
        logic             rank_def;
    } side_t;

    typedef struct packed {
        logic [POS_W-1:0] val;
        logic             sat;
    } clamp_t;

    // Clamp a magnitude to the signed 48-bit range and apply the sign.
    function automatic clamp_t clamp_pos(input logic neg, input logic [QMAG_W-1:0] mag);
        logic [QMAG_W-1:0] limit;
        logic [QMAG_W-1:0] m;
        clamp_t            res;
        limit   = neg ? POS_MAX_MAG + QMAG_W'(1) : POS_MAX_MAG;
        res.sat = mag > limit;
        m       = res.sat ? limit : mag;
        res.val = neg ? POS_W'(QMAG_W'(0) - m) : POS_W'(m);
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/camera_position_from_two_rays.sv
// Least-squares camera centre from two feature/point pairs, fully pipelined.
// Depends on camp_pkg and camp_div.
//
//  channel  ports                      word
//  input    s_valid / s_ready          two features, two points
//  result   m_valid / m_ready          pos_x, pos_y, pos_z, status
//  config   cfg_valid / cfg_ready      min_separation_sq
//
// One word is taken every cycle while the output register is empty or taken; each
// word passes the 48 quotient-bit stages of the cz divider and the product stages.
// All stages advance together whenever the output register is empty or taken,
// so a stalled result holds the whole pipeline without loss.
// Reset (aresetn low, synchronous) empties the pipeline and sets the threshold to 1.
`default_nettype none

module camera_position_from_two_rays (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [camp_pkg::THR_W-1:0]      cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_feat1_u,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_feat1_v,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_pt1_x,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_pt1_y,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_pt1_z,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_feat2_u,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_feat2_v,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_pt2_x,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_pt2_y,
    input  wire logic signed [camp_pkg::IN_W-1:0] s_pt2_z,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [camp_pkg::POS_W-1:0]    m_pos_x,
    output logic signed [camp_pkg::POS_W-1:0]    m_pos_y,
    output logic signed [camp_pkg::POS_W-1:0]    m_pos_z,
    output logic [1:0]                           m_status
);
    import camp_pkg::*;

    logic             adv;
    logic [THR_W-1:0] thr_reg;

    // stage valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg;
    logic q1_valid_reg, q2_valid_reg, q3_valid_reg, q4_valid_reg, m_valid_reg;

    // stage 1
    logic signed [IN_W-1:0]  s1_u1_reg, s1_v1_reg, s1_u2_reg, s1_v2_reg;
    logic signed [IN_W-1:0]  s1_x1_reg, s1_y1_reg, s1_x2_reg, s1_y2_reg;
    logic signed [SUM_W-1:0] s1_du_reg, s1_dv_reg, s1_su_reg, s1_sv_reg;
    logic signed [B_W-1:0]   s1_uz1_reg, s1_vz1_reg, s1_uz2_reg, s1_vz2_reg;
    // stage 2
    logic signed [IN_W-1:0]  s2_u1_reg, s2_v1_reg, s2_u2_reg, s2_v2_reg;
    logic signed [SUM_W-1:0] s2_su_reg, s2_sv_reg;
    logic signed [B_W-1:0]   s2_b1_reg, s2_b2_reg, s2_b3_reg, s2_b4_reg;
    logic [DD_W-1:0]         s2_du2_reg, s2_dv2_reg;
    // stage 3
    logic [DD_W-1:0]         s3_dd_reg, s3_dd_next;
    logic                    s3_def_reg;
    logic signed [SUM_W-1:0] s3_su_reg, s3_sv_reg;
    logic signed [R_W-1:0]   s3_r1_reg, s3_r2_reg;
    logic signed [R_W-1:0]   s3_lo_reg [4];
    logic signed [B_W-1:0]   s3_hi_reg [4];
    logic signed [IN_W-1:0]  s3_f [4];
    logic signed [B_W-1:0]   s3_b [4];
    // stage 4
    logic [DD_W-1:0]         s4_dd_reg;
    logic                    s4_def_reg;
    logic signed [SUM_W-1:0] s4_su_reg, s4_sv_reg;
    logic signed [R_W-1:0]   s4_r1_reg, s4_r2_reg;
    logic signed [T_W-1:0]   s4_t_reg [4];
    logic signed [DD_W-1:0]  s4_m1lo_reg, s4_m1hi_reg, s4_m2lo_reg, s4_m2hi_reg;
    // stage 5
    logic [DD_W-1:0]         s5_dd_reg;
    logic                    s5_def_reg;
    logic signed [SUM_W-1:0] s5_su_reg, s5_sv_reg;
    logic signed [R_W-1:0]   s5_r1_reg, s5_r2_reg;
    logic signed [T_W:0]     s5_ta_reg, s5_tb_reg;
    logic signed [M_W-1:0]   s5_m1_reg, s5_m2_reg;
    // stage 6
    logic [DD_W-1:0]         s6_dd_reg;
    logic                    s6_def_reg;
    logic signed [SUM_W-1:0] s6_su_reg, s6_sv_reg;
    logic signed [R_W-1:0]   s6_r1_reg, s6_r2_reg;
    logic signed [T_W+1:0]   s6_t_reg;
    logic signed [M_W-1:0]   s6_m_reg;
    // stage 7
    logic [DD_W-1:0]         s7_dd_reg;
    side_t                   s7_side_reg;
    logic signed [N_W-1:0]   s7_n2_reg;
    // stage 8
    logic [DD_W-1:0]         s8_dd_reg;
    side_t                   s8_side_reg;
    logic                    s8_neg_reg;
    logic [N_W-1:0]          s8_mag_reg;
    // stage 9
    side_t                   s9_side_reg;
    logic                    s9_neg_reg;
    logic [N_W-1:0]          s9_num_reg;
    logic [D_W-1:0]          s9_den_reg;
    // divider output
    logic                    dv_valid;
    logic [POS_W-1:0]        dv_quo;
    logic                    dv_sat;
    side_t                   dv_side;
    // post-divider stages
    logic signed [POS_W-1:0] q1_cz_reg, q2_cz_reg, q3_cz_reg, q4_cz_reg;
    logic                    q1_sat_reg, q2_sat_reg, q3_sat_reg, q4_sat_reg;
    logic                    q1_def_reg, q2_def_reg, q3_def_reg, q4_def_reg;
    logic signed [R_W-1:0]   q1_r1_reg, q1_r2_reg, q2_r1_reg, q2_r2_reg;
    logic signed [57:0]      q1_xlo_reg, q1_ylo_reg;
    logic signed [56:0]      q1_xhi_reg, q1_yhi_reg;
    logic signed [PR_W-1:0]  q2_px_reg, q2_py_reg, q3_sx_reg, q3_sy_reg;
    logic                    q4_xneg_reg, q4_yneg_reg;
    logic [PR_W-1:0]         q4_xmag_reg, q4_ymag_reg;
    clamp_t                  cx_next, cy_next;
    logic [PR_W-1:0]         rx_next, ry_next;
    logic signed [POS_W-1:0] m_pos_x_reg, m_pos_y_reg, m_pos_z_reg;
    logic [1:0]              m_status_reg, m_status_next;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(1);
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0; s2_valid_reg <= 1'b0; s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0; s5_valid_reg <= 1'b0; s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0; s8_valid_reg <= 1'b0; s9_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0; q2_valid_reg <= 1'b0; q3_valid_reg <= 1'b0;
            q4_valid_reg <= 1'b0; m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;      s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg; s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg; s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg; s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
            q1_valid_reg <= dv_valid;     q2_valid_reg <= q1_valid_reg;
            q3_valid_reg <= q2_valid_reg; q4_valid_reg <= q3_valid_reg;
            m_valid_reg  <= q4_valid_reg;
        end
    end

    // Stage 1: differences, sums and the feature-times-depth products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_u1_reg <= s_feat1_u; s1_v1_reg <= s_feat1_v;
            s1_u2_reg <= s_feat2_u; s1_v2_reg <= s_feat2_v;
            s1_x1_reg <= s_pt1_x;   s1_y1_reg <= s_pt1_y;
            s1_x2_reg <= s_pt2_x;   s1_y2_reg <= s_pt2_y;
            s1_du_reg <= SUM_W'(s_feat1_u) - SUM_W'(s_feat2_u);
            s1_dv_reg <= SUM_W'(s_feat1_v) - SUM_W'(s_feat2_v);
            s1_su_reg <= SUM_W'(s_feat1_u) + SUM_W'(s_feat2_u);
            s1_sv_reg <= SUM_W'(s_feat1_v) + SUM_W'(s_feat2_v);
            s1_uz1_reg <= B_W'(s_feat1_u) * B_W'(s_pt1_z);
            s1_vz1_reg <= B_W'(s_feat1_v) * B_W'(s_pt1_z);
            s1_uz2_reg <= B_W'(s_feat2_u) * B_W'(s_pt2_z);
            s1_vz2_reg <= B_W'(s_feat2_v) * B_W'(s_pt2_z);
        end
    end

    // Stage 2: right-hand side rows and the squared differences.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_u1_reg <= s1_u1_reg; s2_v1_reg <= s1_v1_reg;
            s2_u2_reg <= s1_u2_reg; s2_v2_reg <= s1_v2_reg;
            s2_su_reg <= s1_su_reg; s2_sv_reg <= s1_sv_reg;
            s2_b1_reg <= (B_W'(s1_x1_reg) <<< RHS_SHIFT) - s1_uz1_reg;
            s2_b2_reg <= (B_W'(s1_y1_reg) <<< RHS_SHIFT) - s1_vz1_reg;
            s2_b3_reg <= (B_W'(s1_x2_reg) <<< RHS_SHIFT) - s1_uz2_reg;
            s2_b4_reg <= (B_W'(s1_y2_reg) <<< RHS_SHIFT) - s1_vz2_reg;
            s2_du2_reg <= DD_W'(s1_du_reg) * DD_W'(s1_du_reg);
            s2_dv2_reg <= DD_W'(s1_dv_reg) * DD_W'(s1_dv_reg);
        end
    end

    // Stage 3: separation test, r1 and r2, and each feature times its row
    // taken in two halves of the row.
    assign s3_dd_next = s2_du2_reg + s2_dv2_reg;
    assign s3_f[0] = s2_u1_reg; assign s3_b[0] = s2_b1_reg;
    assign s3_f[1] = s2_v1_reg; assign s3_b[1] = s2_b2_reg;
    assign s3_f[2] = s2_u2_reg; assign s3_b[2] = s2_b3_reg;
    assign s3_f[3] = s2_v2_reg; assign s3_b[3] = s2_b4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_dd_reg  <= s3_dd_next;
            s3_def_reg <= s3_dd_next <= DD_W'(thr_reg);
            s3_su_reg  <= s2_su_reg; s3_sv_reg <= s2_sv_reg;
            s3_r1_reg  <= R_W'(s2_b1_reg) + R_W'(s2_b3_reg);
            s3_r2_reg  <= R_W'(s2_b2_reg) + R_W'(s2_b4_reg);
            for (int i = 0; i < 4; i++) begin
                s3_lo_reg[i] <= R_W'(s3_f[i]) * R_W'($signed({1'b0, s3_b[i][31:0]}));
                s3_hi_reg[i] <= B_W'(s3_f[i]) * B_W'($signed(s3_b[i][B_W-1:32]));
            end
        end
    end

    // Stage 4: rebuild the four products; su*r1 and sv*r2 in two halves.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_dd_reg <= s3_dd_reg; s4_def_reg <= s3_def_reg;
            s4_su_reg <= s3_su_reg; s4_sv_reg <= s3_sv_reg;
            s4_r1_reg <= s3_r1_reg; s4_r2_reg <= s3_r2_reg;
            for (int i = 0; i < 4; i++) begin
                s4_t_reg[i] <= (T_W'(s3_hi_reg[i]) <<< 32) + T_W'(s3_lo_reg[i]);
            end
            s4_m1lo_reg <= DD_W'(s3_su_reg) * DD_W'($signed({1'b0, s3_r1_reg[31:0]}));
            s4_m1hi_reg <= DD_W'(s3_su_reg) * DD_W'($signed(s3_r1_reg[R_W-1:32]));
            s4_m2lo_reg <= DD_W'(s3_sv_reg) * DD_W'($signed({1'b0, s3_r2_reg[31:0]}));
            s4_m2hi_reg <= DD_W'(s3_sv_reg) * DD_W'($signed(s3_r2_reg[R_W-1:32]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_dd_reg <= s4_dd_reg; s5_def_reg <= s4_def_reg;
            s5_su_reg <= s4_su_reg; s5_sv_reg <= s4_sv_reg;
            s5_r1_reg <= s4_r1_reg; s5_r2_reg <= s4_r2_reg;
            s5_ta_reg <= (T_W+1)'(s4_t_reg[0]) + (T_W+1)'(s4_t_reg[1]);
            s5_tb_reg <= (T_W+1)'(s4_t_reg[2]) + (T_W+1)'(s4_t_reg[3]);
            s5_m1_reg <= (M_W'(s4_m1hi_reg) <<< 32) + M_W'(s4_m1lo_reg);
            s5_m2_reg <= (M_W'(s4_m2hi_reg) <<< 32) + M_W'(s4_m2lo_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_dd_reg <= s5_dd_reg; s6_def_reg <= s5_def_reg;
            s6_su_reg <= s5_su_reg; s6_sv_reg <= s5_sv_reg;
            s6_r1_reg <= s5_r1_reg; s6_r2_reg <= s5_r2_reg;
            s6_t_reg  <= (T_W+2)'(s5_ta_reg) + (T_W+2)'(s5_tb_reg);
            s6_m_reg  <= s5_m1_reg + s5_m2_reg;
        end
    end

    // Stage 7: numerator of cz, that is 2*r3 + su*r1 + sv*r2 with r3 = -t.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_dd_reg            <= s6_dd_reg;
            s7_side_reg.r1       <= s6_r1_reg;
            s7_side_reg.r2       <= s6_r2_reg;
            s7_side_reg.su       <= s6_su_reg;
            s7_side_reg.sv       <= s6_sv_reg;
            s7_side_reg.rank_def <= s6_def_reg;
            s7_n2_reg <= N_W'(s6_m_reg) - (N_W'(s6_t_reg) <<< 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_dd_reg   <= s7_dd_reg;
            s8_side_reg <= s7_side_reg;
            s8_neg_reg  <= s7_n2_reg[N_W-1];
            s8_mag_reg  <= s7_n2_reg[N_W-1] ? N_W'(0) - N_W'(s7_n2_reg) : N_W'(s7_n2_reg);
        end
    end

    // Stage 9: rounding to nearest becomes (2|n| + dd) / (2 dd).
    always_ff @(posedge aclk) begin
        if (adv) begin
            s9_side_reg <= s8_side_reg;
            s9_neg_reg  <= s8_neg_reg;
            s9_num_reg  <= (s8_mag_reg << 1) + N_W'(s8_dd_reg);
            s9_den_reg  <= {s8_dd_reg, 1'b0};
        end
    end

    camp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s9_valid_reg),
        .in_neg    (s9_neg_reg),
        .in_num    (s9_num_reg),
        .in_den    (s9_den_reg),
        .in_side   (s9_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sat   (dv_sat),
        .out_side  (dv_side)
    );

    // cx and cy come from the clamped cz: products in two halves of cz.
    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_cz_reg  <= dv_quo;
            q1_sat_reg <= dv_sat;
            q1_def_reg <= dv_side.rank_def;
            q1_r1_reg  <= dv_side.r1;
            q1_r2_reg  <= dv_side.r2;
            q1_xlo_reg <= 58'($signed(dv_side.su)) * 58'($signed({1'b0, dv_quo[CZ_SPLIT-1:0]}));
            q1_xhi_reg <= 57'($signed(dv_side.su)) * 57'($signed(dv_quo[POS_W-1:CZ_SPLIT]));
            q1_ylo_reg <= 58'($signed(dv_side.sv)) * 58'($signed({1'b0, dv_quo[CZ_SPLIT-1:0]}));
            q1_yhi_reg <= 57'($signed(dv_side.sv)) * 57'($signed(dv_quo[POS_W-1:CZ_SPLIT]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q2_cz_reg  <= q1_cz_reg; q2_sat_reg <= q1_sat_reg; q2_def_reg <= q1_def_reg;
            q2_r1_reg  <= q1_r1_reg; q2_r2_reg  <= q1_r2_reg;
            q2_px_reg  <= (PR_W'(q1_xhi_reg) <<< CZ_SPLIT) + PR_W'(q1_xlo_reg);
            q2_py_reg  <= (PR_W'(q1_yhi_reg) <<< CZ_SPLIT) + PR_W'(q1_ylo_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q3_cz_reg <= q2_cz_reg; q3_sat_reg <= q2_sat_reg; q3_def_reg <= q2_def_reg;
            q3_sx_reg <= PR_W'(q2_r1_reg) + q2_px_reg;
            q3_sy_reg <= PR_W'(q2_r2_reg) + q2_py_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q4_cz_reg   <= q3_cz_reg; q4_sat_reg <= q3_sat_reg; q4_def_reg <= q3_def_reg;
            q4_xneg_reg <= q3_sx_reg[PR_W-1];
            q4_yneg_reg <= q3_sy_reg[PR_W-1];
            q4_xmag_reg <= q3_sx_reg[PR_W-1] ? PR_W'(0) - PR_W'(q3_sx_reg) : PR_W'(q3_sx_reg);
            q4_ymag_reg <= q3_sy_reg[PR_W-1] ? PR_W'(0) - PR_W'(q3_sy_reg) : PR_W'(q3_sy_reg);
        end
    end

    // Round half away from zero on the magnitude, then clamp.
    assign rx_next = (q4_xmag_reg + (PR_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    assign ry_next = (q4_ymag_reg + (PR_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    assign cx_next = clamp_pos(q4_xneg_reg, QMAG_W'(rx_next));
    assign cy_next = clamp_pos(q4_yneg_reg, QMAG_W'(ry_next));

    always_comb begin
        if (q4_def_reg) begin
            m_status_next = STATUS_RANK;
        end else if (q4_sat_reg || cx_next.sat || cy_next.sat) begin
            m_status_next = STATUS_SAT;
        end else begin
            m_status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pos_x_reg  <= q4_def_reg ? '0 : cx_next.val;
            m_pos_y_reg  <= q4_def_reg ? '0 : cy_next.val;
            m_pos_z_reg  <= q4_def_reg ? '0 : q4_cz_reg;
            m_status_reg <= m_status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_pos_x  = m_pos_x_reg;
    assign m_pos_y  = m_pos_y_reg;
    assign m_pos_z  = m_pos_z_reg;
    assign m_status = m_status_reg;

endmodule

`default_nettype wire

### rtl/camp_div.sv
// Pipelined restoring divider for cz: one quotient bit per stage, rounded
// numerator in, clamped signed quotient out. Depends on camp_pkg.
`default_nettype none

module camp_div (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic                    in_neg,
    input  wire logic [camp_pkg::N_W-1:0] in_num,
    input  wire logic [camp_pkg::D_W-1:0] in_den,
    input  wire camp_pkg::side_t         in_side,
    output logic                         out_valid,
    output logic [camp_pkg::POS_W-1:0]   out_quo,
    output logic                         out_sat,
    output camp_pkg::side_t              out_side
);
    import camp_pkg::*;

    localparam int STEPS = POS_W;

    logic             valid_reg [STEPS+1];
    logic             neg_reg   [STEPS+1];
    logic             ovf_reg   [STEPS+1];
    logic [REM_W-1:0] rem_reg   [STEPS+1];
    logic [POS_W-1:0] quo_reg   [STEPS+1];
    logic [D_W-1:0]   den_reg   [STEPS+1];
    side_t            side_reg  [STEPS+1];

    logic             out_valid_reg;
    logic [POS_W-1:0] out_quo_reg;
    logic             out_sat_reg;
    side_t            out_side_reg;
    clamp_t           clamp_next;

    // A quotient of 2^48 or more is past any representable result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0]  <= REM_W'(in_num);
            quo_reg[0]  <= '0;
            den_reg[0]  <= in_den;
            neg_reg[0]  <= in_neg;
            ovf_reg[0]  <= REM_W'(in_num) >= (REM_W'(in_den) << STEPS);
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [REM_W-1:0] shifted;
        logic             take;

        assign shifted = REM_W'(den_reg[k-1]) << (STEPS - k);
        assign take    = rem_reg[k-1] >= shifted;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            if (en) begin
                rem_reg[k]  <= take ? rem_reg[k-1] - shifted : rem_reg[k-1];
                quo_reg[k]  <= quo_reg[k-1] | (POS_W'(take) << (STEPS - k));
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign clamp_next = clamp_pos(neg_reg[STEPS],
                                  ovf_reg[STEPS] ? '1 : QMAG_W'(quo_reg[STEPS]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[STEPS];
        end
        if (en) begin
            out_quo_reg  <= clamp_next.val;
            out_sat_reg  <= clamp_next.sat;
            out_side_reg <= side_reg[STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_quo   = out_quo_reg;
    assign out_sat   = out_sat_reg;
    assign out_side  = out_side_reg;

endmodule

`default_nettype wire

### verif/camera_position_from_two_rays_tb.sv
// Self-checking testbench for camera_position_from_two_rays.
// It needs camp_pkg and the solver RTL; it predicts each result itself and compares.
`default_nettype none

module camera_position_from_two_rays_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import camp_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic signed [IN_W-1:0] u1, v1, x1, y1, z1, u2, v2, x2, y2, z2;
    } rays_t;

    typedef struct {
        logic [POS_W-1:0] px, py, pz;
        logic [1:0]       st;
    } centre_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [IN_W-1:0] s_u1 = '0, s_v1 = '0, s_x1 = '0, s_y1 = '0, s_z1 = '0;
    logic signed [IN_W-1:0] s_u2 = '0, s_v2 = '0, s_x2 = '0, s_y2 = '0, s_z2 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [POS_W-1:0] m_pos_x, m_pos_y, m_pos_z;
    logic [1:0] m_status;

    logic [THR_W-1:0] threshold = 41'd1;
    centre_t centres_due[$];
    bit no_idle = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int errors = 0;

    camera_position_from_two_rays DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_feat1_u(s_u1), .s_feat1_v(s_v1), .s_pt1_x(s_x1), .s_pt1_y(s_y1),
        .s_pt1_z(s_z1), .s_feat2_u(s_u2), .s_feat2_v(s_v2), .s_pt2_x(s_x2),
        .s_pt2_y(s_y2), .s_pt2_z(s_z2),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y), .m_pos_z(m_pos_z), .m_status(m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Rounds num/den to nearest, ties away from zero, and clamps to 48 bits.
    function automatic logic [POS_W-1:0] round_clamp(input logic signed [127:0] num,
                                                     input logic [127:0] den,
                                                     inout bit sat);
        logic [127:0] mag, q, lim;
        mag = num < 0 ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        lim = num < 0 ? (128'd1 << 47) : (128'd1 << 47) - 128'd1;
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        return num < 0 ? -q[POS_W-1:0] : q[POS_W-1:0];
    endfunction

    function automatic centre_t solve_centre(input rays_t r);
        logic signed [127:0] u1, v1, x1, y1, z1, u2, v2, x2, y2, z2;
        logic signed [127:0] dd, b1, b2, b3, b4, su, sv, r1, r2, t, n2, cz;
        centre_t c;
        bit sat;
        u1 = r.u1; v1 = r.v1; x1 = r.x1; y1 = r.y1; z1 = r.z1;
        u2 = r.u2; v2 = r.v2; x2 = r.x2; y2 = r.y2; z2 = r.z2;
        sat = 1'b0;
        dd = (u1 - u2) * (u1 - u2) + (v1 - v2) * (v1 - v2);
        if ($unsigned(dd) <= {87'd0, threshold}) begin
            c.px = '0; c.py = '0; c.pz = '0; c.st = STATUS_RANK;
            return c;
        end
        // right-hand side in units of 2^-40
        b1 = (x1 <<< RHS_SHIFT) - u1 * z1;
        b2 = (y1 <<< RHS_SHIFT) - v1 * z1;
        b3 = (x2 <<< RHS_SHIFT) - u2 * z2;
        b4 = (y2 <<< RHS_SHIFT) - v2 * z2;
        su = u1 + u2;
        sv = v1 + v2;
        r1 = b1 + b3;
        r2 = b2 + b4;
        t  = u1 * b1 + v1 * b2 + u2 * b3 + v2 * b4;
        n2 = su * r1 + sv * r2 - 2 * t;
        c.pz = round_clamp(n2, dd, sat);
        cz = $signed(c.pz);
        c.px = round_clamp(r1 + su * cz, 128'd1 << OUT_SHIFT, sat);
        c.py = round_clamp(r2 + sv * cz, 128'd1 << OUT_SHIFT, sat);
        c.st = sat ? STATUS_SAT : STATUS_OK;
        return c;
    endfunction

    task automatic send_rays(input rays_t r);
        if (!no_idle && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_u1 <= r.u1; s_v1 <= r.v1; s_x1 <= r.x1; s_y1 <= r.y1; s_z1 <= r.z1;
        s_u2 <= r.u2; s_v2 <= r.v2; s_x2 <= r.x2; s_y2 <= r.y2; s_z2 <= r.z2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        centres_due.push_back(solve_centre(r));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (centres_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only called with the pipeline empty.
    task automatic write_threshold(input logic [THR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        threshold = v;
    endtask

    function automatic logic [IN_W-1:0] rand_word();
        return $urandom;
    endfunction

    // Mostly plausible geometry with small features, sometimes raw bit patterns.
    function automatic rays_t random_rays();
        rays_t r;
        int mode;
        mode = $urandom_range(9);
        if (mode < 2) begin
            r.u1 = rand_word(); r.v1 = rand_word(); r.x1 = rand_word();
            r.y1 = rand_word(); r.z1 = rand_word(); r.u2 = rand_word();
            r.v2 = rand_word(); r.x2 = rand_word(); r.y2 = rand_word();
            r.z2 = rand_word();
        end else begin
            r.u1 = $signed(rand_word()) >>> $urandom_range(6, 10);
            r.v1 = $signed(rand_word()) >>> $urandom_range(6, 10);
            r.u2 = $signed(rand_word()) >>> $urandom_range(6, 10);
            r.v2 = $signed(rand_word()) >>> $urandom_range(6, 10);
            r.x1 = $signed(rand_word()) >>> $urandom_range(4, 12);
            r.y1 = $signed(rand_word()) >>> $urandom_range(4, 12);
            r.z1 = $signed(rand_word()) >>> $urandom_range(4, 12);
            r.x2 = $signed(rand_word()) >>> $urandom_range(4, 12);
            r.y2 = $signed(rand_word()) >>> $urandom_range(4, 12);
            r.z2 = $signed(rand_word()) >>> $urandom_range(4, 12);
            if (mode == 9) begin
                // nearly coincident features probe the rank threshold
                r.u2 = r.u1 + $signed(IN_W'($urandom_range(0, 4))) - 2;
                r.v2 = r.v1 + $signed(IN_W'($urandom_range(0, 4))) - 2;
            end
        end
        return r;
    endfunction

    task automatic test_directed();
        rays_t r;
        logic signed [IN_W-1:0] vals [4];
        vals = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sd0, -32'sd1};
        // identical features, then separation of one and two ulp squared
        r = '{default: 32'sd1000};
        send_rays(r);
        r.u2 = 32'sd1001;
        send_rays(r);
        r.v2 = 32'sd1001;
        send_rays(r);
        // extremes of every field
        foreach (vals[i]) begin
            r = '{default: vals[i]};
            r.u2 = vals[(i + 1) % 4];
            r.v2 = vals[(i + 2) % 4];
            send_rays(r);
            r.x1 = vals[(i + 3) % 4];
            r.z2 = vals[(i + 1) % 4];
            send_rays(r);
        end
        // opposite extreme features with extreme depths
        r = '{default: 32'sh7FFF_FFFF};
        r.u2 = -32'sh8000_0000; r.v2 = -32'sh8000_0000; r.z1 = -32'sh8000_0000;
        send_rays(r);
        // a well-behaved case: points at depths 5 and 4 with small offsets
        r = '{u1: 32'sh0010_0000, v1: 32'sh0020_0000, x1: 32'sh0001_0000,
              y1: 32'sh0002_0000, z1: 32'sh0005_0000, u2: -32'sh0030_0000,
              v2: 32'sh0008_0000, x2: -32'sh0003_0000, y2: 32'sh0001_8000,
              z2: 32'sh0004_0000};
        send_rays(r);
        wait_drained();
        // with no threshold a one-ulp separation and a huge depth saturate
        write_threshold('0);
        r = '{default: 32'sd0};
        r.u2 = 32'sd1; r.z1 = 32'sh7FFF_FFFF; r.x1 = 32'sh7FFF_FFFF;
        send_rays(r);
        r.z1 = -32'sh8000_0000; r.x1 = -32'sh8000_0000;
        send_rays(r);
        r = '{default: 32'sd0};
        send_rays(r);
        wait_drained();
        write_threshold(41'd1);
    endtask

    task automatic test_random(input logic [THR_W-1:0] thr, input int count);
        write_threshold(thr);
        repeat (count) send_rays(random_rays());
        wait_drained();
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        repeat (200) send_rays(random_rays());
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_requests = hold_requests + 1;
        repeat (150) send_rays(random_rays());
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= no_idle || $urandom_range(99) >= 8;
        end
    end

    always @(posedge aclk) begin
        centre_t c;
        if (aresetn && m_valid && m_ready) begin
            if (centres_due.size() == 0) begin
                $error("result word with nothing expected");
                errors = errors + 1;
            end else begin
                c = centres_due.pop_front();
                if (m_pos_x !== c.px) begin
                    $error("pos_x expected %0h got %0h", c.px, m_pos_x);
                    errors = errors + 1;
                end
                if (m_pos_y !== c.py) begin
                    $error("pos_y expected %0h got %0h", c.py, m_pos_y);
                    errors = errors + 1;
                end
                if (m_pos_z !== c.pz) begin
                    $error("pos_z expected %0h got %0h", c.pz, m_pos_z);
                    errors = errors + 1;
                end
                if (m_status !== c.st) begin
                    $error("status expected %0d got %0d", c.st, m_status);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(41'd1, 300);
        test_random('0, 150);
        test_random(41'h100_0000_0000, 150);
        test_random(THR_W'({$urandom, $urandom}) & 41'h000_FFFF_FFFF, 150);
        test_full_rate();
        test_backpressure();
        test_random(41'd1, 100);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
